@@ rtl/tli_pkg.sv @@
// shared types and constants for the table linear interpolator
// no dependencies; used by every other file of the block
package tli_pkg;

    localparam int TableDepth = 1024;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CountW     = 11;

    // read address select codes
    localparam logic [2:0] RD_ZERO = 3'd0;
    localparam logic [2:0] RD_LAST = 3'd1;
    localparam logic [2:0] RD_ONE  = 3'd2;
    localparam logic [2:0] RD_NEXT = 3'd3;
    localparam logic [2:0] RD_LO   = 3'd4;
    localparam logic [2:0] RD_HI   = 3'd5;

    // region codes
    localparam logic [1:0] REG_BELOW  = 2'd0;
    localparam logic [1:0] REG_INSIDE = 2'd1;
    localparam logic [1:0] REG_ABOVE  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       wr_en;
        logic       capture;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       set_below;
        logic       set_above;
        logic       scan_start;
        logic       scan_step;
        logic       scan_done;
        logic       latch_lo;
        logic       latch_hi;
        logic       part_prep;
        logic       part_sel;
        logic       mul_step;
        logic       div_step;
        logic       part_fin;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic below;
        logic above;
        logic scan_stop;
        logic dk_zero;
    } sts_t;

endpackage

@@ rtl/tli_if.sv @@
// valid/ready channel interfaces for input and result words
// depends on tli_pkg for the index width
interface tli_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [tli_pkg::AddrW-1:0]  entry_index;
    logic [31:0]                entry_key;
    logic signed [31:0]         entry_real;
    logic signed [31:0]         entry_imag;
    logic [31:0]                query_key;

    modport source (output valid, opcode, entry_index, entry_key, entry_real, entry_imag,
                    query_key, input ready);
    modport sink (input valid, opcode, entry_index, entry_key, entry_real, entry_imag,
                  query_key, output ready);
endinterface

interface tli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;
    logic [1:0]         region;
    logic               saturated;

    modport source (output valid, real_out, imag_out, region, saturated, input ready);
    modport sink (input valid, real_out, imag_out, region, saturated, output ready);
endinterface

@@ rtl/tli_dpath.sv @@
// datapath: table memories, bracket scan registers, serial multiplier,
// restoring divider and saturation; depends on tli_pkg
module tli_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tli_pkg::cmd_t                 cmd,
    output tli_pkg::sts_t                 sts,
    input  logic                          cfg_we,
    input  logic [tli_pkg::CountW-1:0]    cfg_wdata,
    input  logic [tli_pkg::AddrW-1:0]     entry_index,
    input  logic [31:0]                   entry_key,
    input  logic signed [31:0]            entry_real,
    input  logic signed [31:0]            entry_imag,
    input  logic [31:0]                   query_key,
    output logic signed [31:0]            real_out,
    output logic signed [31:0]            imag_out,
    output logic [1:0]                    region,
    output logic                          saturated
);

    logic [31:0] key_mem  [tli_pkg::TableDepth];
    logic [31:0] real_mem [tli_pkg::TableDepth];
    logic [31:0] imag_mem [tli_pkg::TableDepth];

    logic [tli_pkg::CountW-1:0] count_reg;
    logic [31:0] key_rd_reg, real_rd_reg, imag_rd_reg;
    logic [31:0] q_reg;
    logic [tli_pkg::AddrW-1:0] last_reg, idx_reg, lo_reg, hi_reg;
    logic [tli_pkg::AddrW-1:0] rd_addr, last_next;
    logic b_hi_reg;
    logic [1:0] region_reg;
    logic [31:0] klo_reg, khi_reg, rlo_reg, rhi_reg, ilo_reg, ihi_reg;
    logic [31:0] mc_reg, dsr_reg, rem_reg;
    logic [63:0] pr_reg;
    logic neg_reg;
    logic signed [31:0] vb_reg;
    logic signed [31:0] res_r_reg, res_i_reg, out_r_reg, out_i_reg;
    logic [1:0] out_reg_region;
    logic clip_reg, out_clip_reg;

    // effective last used entry from the configured count
    always_comb
    begin
        if (count_reg < tli_pkg::CountW'(3))
            last_next = tli_pkg::AddrW'(1);
        else if (count_reg > tli_pkg::CountW'(tli_pkg::TableDepth))
            last_next = tli_pkg::AddrW'(tli_pkg::TableDepth - 2);
        else
            last_next = tli_pkg::AddrW'(count_reg - tli_pkg::CountW'(2));
    end

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            tli_pkg::RD_ZERO: rd_addr = '0;
            tli_pkg::RD_LAST: rd_addr = last_reg;
            tli_pkg::RD_ONE:  rd_addr = tli_pkg::AddrW'(1);
            tli_pkg::RD_NEXT: rd_addr = idx_reg + tli_pkg::AddrW'(1);
            tli_pkg::RD_LO:   rd_addr = lo_reg;
            tli_pkg::RD_HI:   rd_addr = hi_reg;
            default:          rd_addr = '0;
        endcase
    end

    // table memories, one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[entry_index]  <= entry_key;
            real_mem[entry_index] <= entry_real;
            imag_mem[entry_index] <= entry_imag;
        end
        if (cmd.rd_en)
        begin
            key_rd_reg  <= key_mem[rd_addr];
            real_rd_reg <= real_mem[rd_addr];
            imag_rd_reg <= imag_mem[rd_addr];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= tli_pkg::CountW'(3);
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    // status toward the controller
    always_comb
    begin
        sts.below     = q_reg < key_rd_reg;
        sts.above     = q_reg > key_rd_reg;
        sts.scan_stop = (key_rd_reg > q_reg) || (idx_reg == last_reg);
        sts.dk_zero   = khi_reg == klo_reg;
    end

    // part operand selection and arithmetic helpers
    logic [31:0] vlo_sel, vhi_sel, kb_sel;
    logic signed [32:0] dk_s, dq_s, dv_s;
    logic [31:0] dk_mag, dq_mag, dv_mag;
    logic [32:0] mul_sum, rem_sh, rem_sub;
    logic div_ge;
    logic [40:0] quo_c;
    logic signed [41:0] off_s;
    logic signed [42:0] r_s;
    logic signed [31:0] r_sat;
    logic r_clip;

    always_comb
    begin
        vlo_sel = cmd.part_sel ? ilo_reg : rlo_reg;
        vhi_sel = cmd.part_sel ? ihi_reg : rhi_reg;
        kb_sel  = b_hi_reg ? khi_reg : klo_reg;
        dk_s = $signed({1'b0, khi_reg}) - $signed({1'b0, klo_reg});
        dq_s = $signed({1'b0, q_reg}) - $signed({1'b0, kb_sel});
        dv_s = $signed({vhi_sel[31], vhi_sel}) - $signed({vlo_sel[31], vlo_sel});
        dk_mag = dk_s[32] ? 32'(-dk_s) : dk_s[31:0];
        dq_mag = dq_s[32] ? 32'(-dq_s) : dq_s[31:0];
        dv_mag = dv_s[32] ? 32'(-dv_s) : dv_s[31:0];

        // shift-add multiply step
        mul_sum = {1'b0, pr_reg[63:32]} + (pr_reg[0] ? {1'b0, mc_reg} : 33'd0);

        // restoring divide step
        rem_sh  = {rem_reg, pr_reg[63]};
        div_ge  = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};

        // clamp quotient, apply sign, add base and saturate
        if (|pr_reg[63:41] || (pr_reg[40] && |pr_reg[39:0]))
            quo_c = {1'b1, 40'd0};
        else
            quo_c = pr_reg[40:0];
        off_s = neg_reg ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
        r_s   = 43'(vb_reg) + 43'(off_s);
        if (r_s > 43'sd2147483647)
        begin
            r_sat  = 32'sh7fffffff;
            r_clip = 1'b1;
        end
        else if (r_s < -43'sd2147483648)
        begin
            r_sat  = 32'sh80000000;
            r_clip = 1'b1;
        end
        else
        begin
            r_sat  = r_s[31:0];
            r_clip = 1'b0;
        end
        if (sts.dk_zero)
        begin
            r_sat  = vb_reg;
            r_clip = 1'b0;
        end
    end

    // query registers, bracket and arithmetic state
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_reg    <= query_key;
            last_reg <= last_next;
            clip_reg <= 1'b0;
        end
        if (cmd.set_below)
        begin
            region_reg <= tli_pkg::REG_BELOW;
            lo_reg     <= '0;
            hi_reg     <= tli_pkg::AddrW'(1);
            b_hi_reg   <= 1'b0;
        end
        if (cmd.set_above)
        begin
            region_reg <= tli_pkg::REG_ABOVE;
            lo_reg     <= last_reg - tli_pkg::AddrW'(1);
            hi_reg     <= last_reg;
            b_hi_reg   <= 1'b1;
        end
        if (cmd.scan_start)
            idx_reg <= tli_pkg::AddrW'(1);
        if (cmd.scan_step)
            idx_reg <= idx_reg + tli_pkg::AddrW'(1);
        if (cmd.scan_done)
        begin
            region_reg <= tli_pkg::REG_INSIDE;
            lo_reg     <= idx_reg - tli_pkg::AddrW'(1);
            hi_reg     <= idx_reg;
            b_hi_reg   <= 1'b0;
        end
        if (cmd.latch_lo)
        begin
            klo_reg <= key_rd_reg;
            rlo_reg <= real_rd_reg;
            ilo_reg <= imag_rd_reg;
        end
        if (cmd.latch_hi)
        begin
            khi_reg <= key_rd_reg;
            rhi_reg <= real_rd_reg;
            ihi_reg <= imag_rd_reg;
        end
        if (cmd.part_prep)
        begin
            mc_reg  <= dq_mag;
            dsr_reg <= dk_mag;
            pr_reg  <= {32'd0, dv_mag};
            rem_reg <= '0;
            neg_reg <= (dq_s[32] != dv_s[32]) != dk_s[32];
            vb_reg  <= b_hi_reg ? vhi_sel : vlo_sel;
        end
        if (cmd.mul_step)
            pr_reg <= {mul_sum, pr_reg[31:1]};
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
            pr_reg  <= {pr_reg[62:0], div_ge};
        end
        if (cmd.part_fin)
        begin
            if (cmd.part_sel)
                res_i_reg <= r_sat;
            else
                res_r_reg <= r_sat;
            clip_reg <= clip_reg | r_clip;
        end
        if (cmd.out_load)
        begin
            out_r_reg      <= res_r_reg;
            out_i_reg      <= res_i_reg;
            out_reg_region <= region_reg;
            out_clip_reg   <= clip_reg;
        end
    end

    assign real_out  = out_r_reg;
    assign imag_out  = out_i_reg;
    assign region    = out_reg_region;
    assign saturated = out_clip_reg;

endmodule

@@ rtl/tli_ctrl.sv @@
// controller state machine: handshakes, scan sequencing and step counts
// for the serial multiply and divide; depends on tli_pkg
module tli_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_opcode,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output tli_pkg::cmd_t cmd,
    input  tli_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_CHKL  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_FLO   = 4'd4;
    localparam logic [3:0] S_FHI   = 4'd5;
    localparam logic [3:0] S_FCAP  = 4'd6;
    localparam logic [3:0] S_PREP  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic part_reg, part_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire;

    assign in_ready  = state_reg == S_IDLE;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        cmd            = '0;
        cmd.part_sel   = part_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        part_next      = part_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tli_pkg::RD_ZERO;
                if (in_fire)
                begin
                    if (in_opcode == tli_pkg::OP_WRITE)
                        cmd.wr_en = 1'b1;
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_CHK0;
                    end
                end
            end
            S_CHK0:
            begin
                if (sts.below)
                begin
                    cmd.set_below = 1'b1;
                    state_next    = S_FLO;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tli_pkg::RD_LAST;
                    state_next = S_CHKL;
                end
            end
            S_CHKL:
            begin
                if (sts.above)
                begin
                    cmd.set_above = 1'b1;
                    state_next    = S_FLO;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = tli_pkg::RD_ONE;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_stop)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = S_FLO;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = tli_pkg::RD_NEXT;
                end
            end
            S_FLO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tli_pkg::RD_LO;
                state_next = S_FHI;
            end
            S_FHI:
            begin
                cmd.latch_lo = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = tli_pkg::RD_HI;
                state_next   = S_FCAP;
            end
            S_FCAP:
            begin
                cmd.latch_hi = 1'b1;
                part_next    = 1'b0;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.part_prep = 1'b1;
                cnt_next      = '0;
                state_next    = sts.dk_zero ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.part_fin = 1'b1;
                if (part_reg)
                    state_next = S_OUT;
                else
                begin
                    part_next  = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            part_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/table_linear_interpolator_core.sv @@
// Piecewise linear interpolator over a loadable table of keyed complex values.
// Input words on in_ch: opcode 0 writes entry entry_index (key, real, imag)
// and gives no result; opcode 1 queries at query_key and gives one result
// word on out_ch (real_out, imag_out, region, saturated).
// A query reads key 0 and, unless the query is below it, the last used key;
// if it lies between them, it scans keys 1..last one per cycle until the
// first key above the query or the last key. It then fetches the two
// bracketing entries and runs a 32-step shift-add multiply and a 64-step
// restoring divide for each of the two parts on one shared unit; a part
// whose bracketing keys are equal skips its multiply and divide.
// One query is worked on at a time; in_ch is ready only when idle.
// The result sits in an output register: the next word is accepted while it
// waits, and a finished query holds until out_ch takes the previous one.
// entry_count is to be written through cfg_we/cfg_wdata only while idle;
// the block itself does not enforce this. Reset sets it to 3 and clears
// control state; table contents are undefined until written.
// Depends on tli_pkg, tli_if, tli_ctrl and tli_dpath.
module table_linear_interpolator_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tli_pkg::CountW-1:0] cfg_wdata,
    tli_in_if.sink                     in_ch,
    tli_out_if.source                  out_ch
);

    tli_pkg::cmd_t cmd;
    tli_pkg::sts_t sts;

    // controller
    tli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath
    tli_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_index (in_ch.entry_index),
        .entry_key   (in_ch.entry_key),
        .entry_real  (in_ch.entry_real),
        .entry_imag  (in_ch.entry_imag),
        .query_key   (in_ch.query_key),
        .real_out    (out_ch.real_out),
        .imag_out    (out_ch.imag_out),
        .region      (out_ch.region),
        .saturated   (out_ch.saturated)
    );

endmodule

@@ tb/sv/table_linear_interpolator_core_tb.sv @@
// self-checking testbench for table_linear_interpolator_core: loads tables,
// sweeps entry_count and checks every query word against an internal predictor
// depends on tli_pkg, tli_if and the core rtl
`timescale 1ns / 1ps

module table_linear_interpolator_core_tb;

    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         region;
        logic               sat;
    } lerp_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tli_pkg::CountW-1:0] cfg_wdata;

    tli_in_if  in_ch ();
    tli_out_if out_ch ();

    table_linear_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    bit [31:0]   tbl_key [tli_pkg::TableDepth];
    bit [31:0]   tbl_re [tli_pkg::TableDepth];
    bit [31:0]   tbl_im [tli_pkg::TableDepth];
    bit [tli_pkg::CountW-1:0] count_reg;
    int          loaded_upto;
    lerp_word_t  pending_words [$];

    bit          gaps_on;
    int          words_sent;
    int          queries_sent;
    int          results_seen;
    int          region_hits [3];
    int          sat_hits;
    int          errors;
    int          idle_cycles;
    int          stall_left;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // one part of the interpolation, exact signed arithmetic
    function automatic bit [31:0] lerp_part(bit [31:0] vb, bit [31:0] vlo, bit [31:0] vhi,
                                            bit [31:0] kb, bit [31:0] klo, bit [31:0] khi,
                                            bit [31:0] q, ref bit clip);
        longint    dk;
        longint    dq;
        longint    dv;
        longint    off;
        longint    r;
        bit        neg;
        bit [63:0] mq;
        bit [63:0] mv;
        bit [63:0] mk;
        bit [63:0] quo;
        dk = longint'(khi) - longint'(klo);
        if (dk == 0)
            return vb;
        dq = longint'(q) - longint'(kb);
        dv = longint'(signed'(vhi)) - longint'(signed'(vlo));
        neg = ((dq < 0) != (dv < 0)) != (dk < 0);
        mq = (dq < 0) ? -dq : dq;
        mv = (dv < 0) ? -dv : dv;
        mk = (dk < 0) ? -dk : dk;
        quo = (mq * mv) / mk;
        if (quo > (64'd1 << 40))
            quo = 64'd1 << 40;
        off = neg ? -longint'(quo) : longint'(quo);
        r = longint'(signed'(vb)) + off;
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
            clip = 1'b1;
        end
        else if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
            clip = 1'b1;
        end
        return r[31:0];
    endfunction

    function automatic int last_used();
        int cnt;
        cnt = count_reg;
        if (cnt < 3)
            cnt = 3;
        if (cnt > tli_pkg::TableDepth)
            cnt = tli_pkg::TableDepth;
        return cnt - 2;
    endfunction

    // expected word for a query at q
    function automatic lerp_word_t interpolate(bit [31:0] q);
        lerp_word_t w;
        int  last;
        int  b;
        int  lo;
        int  hi;
        bit  clip;
        bit  found;
        last = last_used();
        clip = 1'b0;
        found = 1'b0;
        if (q < tbl_key[0])
        begin
            w.region = tli_pkg::REG_BELOW;
            b = 0; lo = 0; hi = 1;
        end
        else if (q > tbl_key[last])
        begin
            w.region = tli_pkg::REG_ABOVE;
            b = last; lo = last - 1; hi = last;
        end
        else
        begin
            w.region = tli_pkg::REG_INSIDE;
            lo = last - 1; hi = last;
            for (int i = 1; i <= last && !found; i++)
            begin
                if (tbl_key[i] > q)
                begin
                    hi = i; lo = i - 1; found = 1'b1;
                end
            end
            b = lo;
        end
        w.re = lerp_part(tbl_re[b], tbl_re[lo], tbl_re[hi], tbl_key[b], tbl_key[lo],
                         tbl_key[hi], q, clip);
        w.im = lerp_part(tbl_im[b], tbl_im[lo], tbl_im[hi], tbl_key[b], tbl_key[lo],
                         tbl_key[hi], q, clip);
        w.sat = clip;
        return w;
    endfunction

    // send one input word, update predictor on acceptance
    task automatic send_word(logic op, logic [tli_pkg::AddrW-1:0] idx, logic [31:0] k,
                             logic [31:0] re, logic [31:0] im, logic [31:0] q);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.entry_index <= idx;
        in_ch.entry_key   <= k;
        in_ch.entry_real  <= re;
        in_ch.entry_imag  <= im;
        in_ch.query_key   <= q;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
        if (op == tli_pkg::OP_WRITE)
        begin
            tbl_key[idx] = k;
            tbl_re[idx] = re;
            tbl_im[idx] = im;
        end
        else
        begin
            queries_sent++;
            pending_words.push_back(interpolate(q));
        end
    endtask

    task automatic write_entry(int idx, bit [31:0] k, bit [31:0] re, bit [31:0] im);
        send_word(tli_pkg::OP_WRITE, idx[tli_pkg::AddrW-1:0], k, re, im, $urandom);
    endtask

    task automatic query(bit [31:0] q);
        send_word(tli_pkg::OP_QUERY, tli_pkg::AddrW'($urandom), $urandom, $urandom,
                  $urandom, q);
    endtask

    // wait until every expected word has come back, then let the core settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_count(int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[tli_pkg::CountW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_reg = value[tli_pkg::CountW-1:0];
    endtask

    // fill entries 0..n-1; style picks sorted wide, dense with repeats, or unsorted
    task automatic load_table(int n, int style);
        bit [31:0] k;
        bit [31:0] re;
        bit [31:0] im;
        k = (style == 0) ? $urandom_range(0, 1000) : $urandom;
        for (int i = 0; i < n; i++)
        begin
            re = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            im = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            write_entry(i, k, re, im);
            case (style)
                0: k = k + $urandom_range(1, 32'h00ffffff / n);
                1: k = k + $urandom_range(0, 3);
                default: k = $urandom;
            endcase
        end
        if (n > loaded_upto)
            loaded_upto = n;
    endtask

    function automatic bit [31:0] pick_query(int last);
        int r;
        r = $urandom_range(0, last);
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return tbl_key[r];
            3: return tbl_key[r] + $urandom_range(0, 64) - 32;
            4: return $urandom;
            default: return tbl_key[r] + (tbl_key[r + 1 > last ? last : r + 1] - tbl_key[r]) / 2;
        endcase
    endfunction

    // directed: each region, exact key hits, clipping, equal keys, low counts
    task automatic test_directed();
        set_count(3);
        write_entry(0, 1000, 32'h0001_0000, 32'hffff_0000);
        write_entry(1, 3000, 32'h0003_0000, 32'h0000_0000);
        write_entry(2, 5000, 32'h0005_0000, 32'h0001_0000);
        loaded_upto = 3;
        query(0);
        query(1000);
        query(2000);
        query(3000);
        query(32'hffffffff);
        // steep slope clips in both directions
        write_entry(1, 1001, 32'h7fff_0000, 32'h8000_0000);
        query(32'hffffffff);
        query(0);
        // repeated key gives the base value
        write_entry(1, 1000, 32'h1234_5678, 32'h8765_4321);
        query(999);
        query(1000);
        query(32'hffffffff);
        // counts below the minimum act as 3
        set_count(0);
        write_entry(1, 4000, 32'h8000_0000, 32'h7fff_ffff);
        query(2500);
        query(500);
        set_count(1);
        query(4000);
        set_count(2);
        query(5000);
        set_count(4);
        query(4500);
        query(5000);
        query(6000);
    endtask

    // full depth table, the largest counts and out of range count
    task automatic test_full_depth();
        set_count(3);
        load_table(tli_pkg::TableDepth, 0);
        set_count(2047);
        for (int i = 0; i < 4; i++)
            query(pick_query(tli_pkg::TableDepth - 2));
        set_count(tli_pkg::TableDepth);
        for (int i = 0; i < 4; i++)
            query(pick_query(tli_pkg::TableDepth - 2));
        query(32'hffffffff);
    endtask

    // random phases: new count, a fresh table of random shape in most phases, mixed words
    task automatic test_random(int target);
        int cnt;
        int last;
        int n;
        while (words_sent < target)
        begin
            case ($urandom_range(0, 9))
                0: cnt = $urandom_range(0, 2);
                1: cnt = $urandom_range(3, 200);
                2: cnt = (loaded_upto >= tli_pkg::TableDepth) ? $urandom_range(1025, 2047) : 3;
                default: cnt = $urandom_range(3, 24);
            endcase
            set_count(cnt);
            last = last_used();
            if ($urandom_range(0, 3) != 0 || last + 1 > loaded_upto)
                load_table(last + 1, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
            n = $urandom_range(10, 40);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_entry($urandom_range(0, last), $urandom, $urandom, $urandom);
                else
                    query(pick_query(last));
            end
        end
    endtask

    // result side backpressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left  <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left  <= $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        lerp_word_t exp_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result word re=%h im=%h region=%0d sat=%0b", $time,
                         out_ch.real_out, out_ch.imag_out, out_ch.region, out_ch.saturated);
                errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (exp_w.region < 3)
                    region_hits[exp_w.region]++;
                sat_hits += exp_w.sat;
                if (out_ch.real_out !== exp_w.re || out_ch.imag_out !== exp_w.im ||
                    out_ch.region !== exp_w.region || out_ch.saturated !== exp_w.sat)
                begin
                    $display("%0t: expected re=%h im=%h region=%0d sat=%0b", $time,
                             exp_w.re, exp_w.im, exp_w.region, exp_w.sat);
                    $display("%0t: actual   re=%h im=%h region=%0d sat=%0b", $time,
                             out_ch.real_out, out_ch.imag_out, out_ch.region,
                             out_ch.saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("table_linear_interpolator_core: mismatch");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = tli_pkg::OP_WRITE;
        in_ch.entry_index = '0;
        in_ch.entry_key   = '0;
        in_ch.entry_real  = '0;
        in_ch.entry_imag  = '0;
        in_ch.query_key   = '0;
        out_ch.ready      = 1'b1;
        count_reg         = 3;
        loaded_upto       = 0;
        gaps_on           = 1'b1;
        words_sent        = 0;
        queries_sent      = 0;
        results_seen      = 0;
        sat_hits          = 0;
        errors            = 0;
        idle_cycles       = 0;
        stall_left        = 0;
        region_hits       = '{0, 0, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(600);
        test_full_depth();
        drain();
        // closing phase with no idling on either side
        gaps_on = 1'b0;
        test_random((words_sent < 1890) ? 1950 : words_sent + 60);
        drain();
        repeat (50) @(posedge clk);

        $display("sent %0d words (%0d queries), checked %0d results", words_sent,
                 queries_sent, results_seen);
        $display("regions below/inside/above: %0d/%0d/%0d, clipped: %0d",
                 region_hits[0], region_hits[1], region_hits[2], sat_hits);
        if (errors == 0 && pending_words.size() == 0)
            $display("table_linear_interpolator_core: match");
        else
            $display("table_linear_interpolator_core: mismatch");
        $finish;
    end

endmodule
